[hw/rtl/cbt_pkg.sv]
// Package for the cubic Bezier tessellator: sequencer state and step codes,
// fixed-point constants and the output saturation helper.
// No dependencies; imported by cubic_bezier_tessellator.
package cbt_pkg;

   // Sequencer states of the tessellator.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_CALC,
      ST_ROUND
   } cbt_state_type;

   // Step codes of the shared multiplier within one curve point.
   localparam logic [3:0] STEP_BB   = 4'd0;   // b * b
   localparam logic [3:0] STEP_TT   = 4'd1;   // t * t
   localparam logic [3:0] STEP_W0   = 4'd2;   // b^2 * b
   localparam logic [3:0] STEP_W1   = 4'd3;   // b^2 * t
   localparam logic [3:0] STEP_W2   = 4'd4;   // t^2 * b
   localparam logic [3:0] STEP_W3   = 4'd5;   // t^2 * t
   localparam logic [3:0] STEP_AX   = 4'd6;
   localparam logic [3:0] STEP_BX   = 4'd7;
   localparam logic [3:0] STEP_CX   = 4'd8;
   localparam logic [3:0] STEP_DX   = 4'd9;
   localparam logic [3:0] STEP_AY   = 4'd10;
   localparam logic [3:0] STEP_BY   = 4'd11;
   localparam logic [3:0] STEP_CY   = 4'd12;
   localparam logic [3:0] STEP_DY   = 4'd13;
   localparam logic [3:0] STEP_LAST = 4'd14;  // final accumulate, no product issued

   localparam logic [16:0] ONE_Q16     = 17'h10000;
   localparam logic [65:0] HALF_Q48    = 66'd1 << 47;
   localparam logic [6:0]  CFG_RESET   = 7'd10;
   localparam logic [6:0]  MIN_POINTS  = 7'd2;
   localparam logic [6:0]  MAX_POINTS  = 7'd64;
   localparam logic [4:0]  DIV_LAST    = 5'd16;  // 17 quotient bits, MSB first

   // Clamp an 18-bit signed integer to the signed 16-bit Q12.4 range.
   function automatic logic [15:0] sat_q12_4(input logic signed [17:0] v);
      logic [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/cubic_bezier_tessellator.sv]
// Cubic Bezier tessellator: collects four control points and emits the
// evaluated curve points. Depends on cbt_pkg.
//
// The block accepts 2D control points (signed Q12.4) on the req_ stream and
// groups them by four as A, B, C and D. The first three points of a group are
// stored, and req_tready stays high for them; the fourth starts a segment,
// during which req_tready is low. A segment first runs a restoring divider
// that splits 1.0 (65536 in Q1.16) by N-1, N being points_per_segment
// clamped to 2..64. After that, t steps from 0 to exactly 1.0 by adding the
// quotient and carrying the remainder, so every t equals n*65536/(N-1)
// rounded to nearest. For each curve point, one signed 50x18 multiplier is
// shared over fifteen steps that form b^2, t^2, the four Bernstein weights and
// the eight coordinate products (a register follows the multiplier, and the
// products are summed one step later); a round state then rounds to nearest
// (ties up), saturates and loads the output register once it is free. The
// output register decouples the rsp_ side: the next point is computed while
// a finished one waits, and the last point of a segment may still wait while
// the next group's points are taken in. rsp_tlast marks the last point of
// each segment. A trailing group of fewer than four points never produces
// output. points_per_segment is written through csr_wr_en/csr_wr_data and
// must only change while the block is idle; it resets to 10.
module cubic_bezier_tessellator
   import cbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Control point input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] point_x, [31:16] point_y
   // Curve point output stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] curve_x, [31:16] curve_y
   output logic        rsp_tlast,   // last_of_segment
   // Configuration register points_per_segment.
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   cbt_state_type state_ff, state_in;

   logic [6:0]  cfg_ff;
   logic [1:0]  grp_ff;
   logic [31:0] held_ff [3];   // {y, x} of A, B, C
   logic [31:0] d_ff;          // {y, x} of D

   logic [5:0]  den_ff;
   logic [5:0]  den_sel;
   logic [5:0]  div_rem_ff;
   logic [16:0] div_quo_ff;
   logic [4:0]  div_cnt_ff;

   logic [16:0] t_ff;
   logic [5:0]  r_ff;
   logic [5:0]  n_ff;
   logic [3:0]  step_ff;

   logic [33:0] b2_ff, t2_ff;
   logic [48:0] w_ff [4];
   logic signed [65:0] prod_ff;
   logic signed [65:0] acc_x_ff, acc_y_ff;

   logic [15:0] rsp_x_ff, rsp_y_ff;
   logic        rsp_last_ff;
   logic        rsp_valid_ff;

   logic        req_fire;
   logic        load;
   logic        last_pt;

   // Divider step.
   logic [6:0]  div_sh;
   logic        div_ge;
   logic [6:0]  div_diff;

   // t advance.
   logic [6:0]  r_sum;
   logic        r_ge;
   logic [6:0]  r_wrap;

   // Shared multiplier.
   logic [16:0]        b_val;
   logic signed [49:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [67:0] mul_p;
   logic [49:0]        prod_x3;

   // Rounding.
   logic signed [65:0] sum_x, sum_y;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign last_pt = (n_ff == den_ff);
   assign load    = (state_ff == ST_ROUND) && (!rsp_valid_ff || rsp_tready);

   // Effective N-1 from the register, N clamped to 2..64.
   always_comb begin
      logic [6:0] dm1;
      dm1 = cfg_ff - 7'd1;
      priority if (cfg_ff < MIN_POINTS) begin
         den_sel = 6'd1;
      end else if (cfg_ff > MAX_POINTS) begin
         den_sel = 6'd63;
      end else begin
         den_sel = dm1[5:0];
      end
   end

   // One restoring step of 65536 / (N-1); the dividend's only set bit is the MSB.
   assign div_sh   = {div_rem_ff, (div_cnt_ff == 5'd0)};
   assign div_ge   = (div_sh >= {1'b0, den_ff});
   assign div_diff = div_sh - {1'b0, den_ff};

   // Next t: add the quotient and carry the remainder.
   assign r_sum  = {1'b0, r_ff} + {1'b0, div_rem_ff};
   assign r_ge   = (r_sum >= {1'b0, den_ff});
   assign r_wrap = r_sum - {1'b0, den_ff};

   assign b_val = ONE_Q16 - t_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         STEP_BB: begin mul_a = {33'd0, b_val}; mul_b = {1'b0, b_val}; end
         STEP_TT: begin mul_a = {33'd0, t_ff};  mul_b = {1'b0, t_ff};  end
         STEP_W0: begin mul_a = {16'd0, b2_ff}; mul_b = {1'b0, b_val}; end
         STEP_W1: begin mul_a = {16'd0, b2_ff}; mul_b = {1'b0, t_ff};  end
         STEP_W2: begin mul_a = {16'd0, t2_ff}; mul_b = {1'b0, b_val}; end
         STEP_W3: begin mul_a = {16'd0, t2_ff}; mul_b = {1'b0, t_ff};  end
         STEP_AX: begin
            mul_a = {1'b0, w_ff[0]};
            mul_b = {{2{held_ff[0][15]}}, held_ff[0][15:0]};
         end
         STEP_BX: begin
            mul_a = {1'b0, w_ff[1]};
            mul_b = {{2{held_ff[1][15]}}, held_ff[1][15:0]};
         end
         STEP_CX: begin
            mul_a = {1'b0, w_ff[2]};
            mul_b = {{2{held_ff[2][15]}}, held_ff[2][15:0]};
         end
         STEP_DX: begin
            mul_a = {1'b0, w_ff[3]};
            mul_b = {{2{d_ff[15]}}, d_ff[15:0]};
         end
         STEP_AY: begin
            mul_a = {1'b0, w_ff[0]};
            mul_b = {{2{held_ff[0][31]}}, held_ff[0][31:16]};
         end
         STEP_BY: begin
            mul_a = {1'b0, w_ff[1]};
            mul_b = {{2{held_ff[1][31]}}, held_ff[1][31:16]};
         end
         STEP_CY: begin
            mul_a = {1'b0, w_ff[2]};
            mul_b = {{2{held_ff[2][31]}}, held_ff[2][31:16]};
         end
         STEP_DY: begin
            mul_a = {1'b0, w_ff[3]};
            mul_b = {{2{d_ff[31]}}, d_ff[31:16]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_x3 = {prod_ff[48:0], 1'b0} + prod_ff[49:0];

   // Round half up by adding one half and keeping the integer part.
   assign sum_x = acc_x_ff + $signed(HALF_Q48);
   assign sum_y = acc_y_ff + $signed(HALF_Q48);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (grp_ff == 2'd3)) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (load) begin
               state_in = last_pt ? ST_IDLE : ST_CALC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration, group count and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         grp_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (req_fire) begin
            grp_ff <= grp_ff + 2'd1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      prod_ff <= mul_p[65:0];

      if (req_fire) begin
         if (grp_ff == 2'd3) begin
            d_ff       <= {req_tdata[31:16], req_tdata[15:0]};
            den_ff     <= den_sel;
            div_rem_ff <= 6'd0;
            div_quo_ff <= 17'd0;
            div_cnt_ff <= 5'd0;
            t_ff       <= 17'd0;
            r_ff       <= {1'b0, den_sel[5:1]};
            n_ff       <= 6'd0;
            step_ff    <= STEP_BB;
         end else begin
            held_ff[grp_ff] <= req_tdata;
         end
      end

      if (state_ff == ST_DIV) begin
         div_rem_ff <= div_ge ? div_diff[5:0] : div_sh[5:0];
         div_quo_ff <= {div_quo_ff[15:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end

      if (state_ff == ST_CALC) begin
         step_ff <= step_ff + 4'd1;
         unique case (step_ff)
            STEP_BB: begin
               acc_x_ff <= '0;
               acc_y_ff <= '0;
            end
            STEP_TT: b2_ff   <= prod_ff[33:0];
            STEP_W0: t2_ff   <= prod_ff[33:0];
            STEP_W1: w_ff[0] <= prod_ff[48:0];
            STEP_W2: w_ff[1] <= prod_x3[48:0];
            STEP_W3: w_ff[2] <= prod_x3[48:0];
            STEP_AX: w_ff[3] <= prod_ff[48:0];
            STEP_BX, STEP_CX, STEP_DX, STEP_AY: acc_x_ff <= acc_x_ff + prod_ff;
            STEP_BY, STEP_CY, STEP_DY, STEP_LAST: acc_y_ff <= acc_y_ff + prod_ff;
            default: ;
         endcase
      end

      if (load) begin
         rsp_x_ff    <= sat_q12_4(sum_x[65:48]);
         rsp_y_ff    <= sat_q12_4(sum_y[65:48]);
         rsp_last_ff <= last_pt;
         t_ff        <= t_ff + div_quo_ff + {16'd0, r_ge};
         r_ff        <= r_ge ? r_wrap[5:0] : r_sum[5:0];
         n_ff        <= n_ff + 6'd1;
         step_ff     <= STEP_BB;
      end
   end

   // The divisor is never zero once a point is being evaluated.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (den_ff != 6'd0))
      else $error("segment divisor is zero");

   // The carried remainder of t stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (r_ff < den_ff))
      else $error("t remainder out of range");

   // The last point of a segment is evaluated at exactly t = 1.0.
   a_t_end: assert property (@(posedge clock) disable iff (reset)
      (load && last_pt) |-> (t_ff == ONE_Q16))
      else $error("t does not reach one on the last point");

   // The fourth point of a group starts the divider.
   a_seg_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (grp_ff == 2'd3)) |=> (state_ff == ST_DIV))
      else $error("segment did not start after fourth point");

   // The step counter never runs past the final accumulate.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (step_ff <= STEP_LAST))
      else $error("multiplier step out of range");

endmodule

[test/cubic_bezier_tessellator_tb.sv]
// Self-checking testbench for the cubic Bezier tessellator: a directed table of
// control points, then random groups, checked against typed rows or the in-bench predictor.
// Depends on cbt_pkg and cubic_bezier_tessellator; needs no files or arguments.
module cubic_bezier_tessellator_tb;
   import cbt_pkg::*;

   // The watchdog ends the run after this many cycles in which no transfer
   // happens on either stream. The longest quiet stretch in a correct run is
   // the receiver's deliberate hold-off, so the limit is several times that.
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int WATCHDOG_LIMIT  = 4000;
   // Cycles to let pass before a register write once the last curve point has
   // arrived: a merely stored control point needs no more work, so this is ample.
   localparam int CFG_SETTLE      = 20;
   localparam int RANDOM_ITEMS    = 125;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } curve_point_type;

   // One row of the directed table. A row with set_cfg writes the register
   // first. A row with typed carries the point that every curve point of the
   // segment it completes must equal; other rows use the predictor's points.
   typedef struct packed {
      logic        set_cfg;
      logic [6:0]  cfg;
      logic [15:0] x;
      logic [15:0] y;
      logic        typed;
      logic [15:0] typed_x;
      logic [15:0] typed_y;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Two groups of four identical points at corners of the range, default of ten
      // points per segment: the curve collapses onto that point exactly.
      '{1'b0, 7'd0,  16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
      '{1'b0, 7'd0,  16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
      '{1'b0, 7'd0,  16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
      '{1'b0, 7'd0,  16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
      '{1'b0, 7'd0,  16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
      '{1'b0, 7'd0,  16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
      '{1'b0, 7'd0,  16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
      '{1'b0, 7'd0,  16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
      // Three points: the midpoint lands on +0.5 LSB in x and -0.5 LSB in y, so both
      // rounding ties are hit (they go toward +infinity).
      '{1'b1, 7'd3,  16'h0004, 16'hFFFC, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      // Smallest segment: only the two end points come out.
      '{1'b1, 7'd2,  16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'h1234, 16'hFEDC, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
      // Largest segment with the control points on the extremes.
      '{1'b1, 7'd64, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
      // A group left open: the register write that opens the random part
      // lands in the middle of it, and the held points must survive.
      '{1'b0, 7'd0,  16'h0001, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'h7FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 7'd0,  16'hFFFF, 16'h0001, 1'b0, 16'h0000, 16'h0000}
   };

   // Register values for the first random phases: both ends of the 7-bit
   // field, a legal value, the clamped values just outside the legal range
   // and its edges. The third phase carries the long receiver hold-off.
   localparam logic [6:0] EDGE_CFG [7] = '{7'd0, 7'd127, 7'd4, 7'd1, 7'd64, 7'd65, 7'd2};
   localparam int HOLD_PHASE = 2;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;

   // Predictor state: the points held in the open group, how many there are,
   // and the mirror of the points_per_segment register.
   logic [15:0]     held_x [3];
   logic [15:0]     held_y [3];
   int unsigned     held_count;
   logic [6:0]      segment_points_reg;
   curve_point_type segment_pts [MAX_POINTS];
   curve_point_type curve_expected [$];

   int   error_count;
   int   burst_left;
   int   idle_cycles;
   logic hold_request;
   logic end_drain;

   cubic_bezier_tessellator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [15:0] point_x, [31:16] point_y
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [15:0] curve_x, [31:16] curve_y
      .rsp_tlast   (rsp_tlast),    // last_of_segment
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Weighted sum of four coordinates with Q.48 weights that add up to 2^48.
   // The sum is exact in 72 bits; adding half an LSB and shifting arithmetically
   // rounds to nearest with ties toward +infinity.
   function automatic logic [15:0] bezier_blend(input logic signed [15:0] a, b, c, d,
                                                input logic signed [71:0] wa, wb, wc, wd);
      logic signed [71:0] acc;
      acc = a * wa + b * wb + c * wc + d * wd + (72'sd1 <<< 47);
      acc = acc >>> 48;
      if (acc > 32767) return 16'h7FFF;
      if (acc < -32768) return 16'h8000;
      return acc[15:0];
   endfunction

   // Takes one control point into the predictor. The first three points of a
   // group are only held; the fourth fills segment_pts with the curve points
   // of the segment and returns how many there are.
   function automatic int tessellate(input logic [15:0] px, py);
      int unsigned        cnt;
      int unsigned        den;
      logic signed [71:0] t;
      logic signed [71:0] b;
      logic signed [71:0] w0, w1, w2, w3;
      if (held_count < 3) begin
         held_x[held_count] = px;
         held_y[held_count] = py;
         held_count++;
         return 0;
      end
      held_count = 0;
      cnt = 32'(segment_points_reg);
      if (cnt < MIN_POINTS) cnt = 32'(MIN_POINTS);
      if (cnt > MAX_POINTS) cnt = 32'(MAX_POINTS);
      den = cnt - 1;
      for (int n = 0; n < cnt; n++) begin
         // t in Q0.16 with one extra integer bit, rounded to nearest.
         t  = 72'((n * ONE_Q16 + den / 2) / den);
         b  = 72'(ONE_Q16) - t;
         w0 = b * b * b;
         w1 = 3 * b * b * t;
         w2 = 3 * b * t * t;
         w3 = t * t * t;
         segment_pts[n].x    = bezier_blend(held_x[0], held_x[1], held_x[2], px,
                                            w0, w1, w2, w3);
         segment_pts[n].y    = bezier_blend(held_y[0], held_y[1], held_y[2], py,
                                            w0, w1, w2, w3);
         segment_pts[n].last = (n == den);
      end
      return cnt;
   endfunction

   // Random coordinate: extremes, values around zero, or anything.
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] want, got);
      $display("mismatch on %s: expected %h, got %h", what, want, got);
      error_count++;
   endtask

   // Offers one control point and returns at the falling edge after its
   // transfer. The sender works in bursts: when a burst is used up, valid
   // drops for a random gap that may be zero and a new burst length is drawn.
   // Valid stays high between items of a burst. Called at a falling edge.
   task automatic send_point(input logic [15:0] x, y, input logic typed,
                             input logic [15:0] typed_x, typed_y);
      int              gap;
      int              produced;
      curve_point_type pt;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid = 1'b1;
      req_tdata  = {y, x};
      do @(posedge clock); while (!req_tready);
      produced = tessellate(x, y);
      for (int i = 0; i < produced; i++) begin
         if (typed) begin
            pt.x    = typed_x;
            pt.y    = typed_y;
            pt.last = (i == produced - 1);
         end else begin
            pt = segment_pts[i];
         end
         curve_expected.insert(curve_expected.size(), pt);
      end
      burst_left--;
      @(negedge clock);
   endtask

   // Writes points_per_segment once the block is idle: the sender stops, every
   // expected curve point must have been taken, and a few cycles pass for a
   // point that was only stored. Called and returns at a falling edge.
   task automatic write_segment_points(input logic [6:0] value);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (curve_expected.size() != 0) @(negedge clock);
      repeat (CFG_SETTLE) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en          = 1'b0;
      segment_points_reg = value;
   endtask

   // Receiver. tready changes at the falling edge and follows a mode that is
   // redrawn after a random run: always ready, coin flip, mostly stalled,
   // or a rotating bit pattern. On request it holds off for a long stretch so
   // that the output register and then the input side fill up. In the final drain it is always ready.
   initial begin : receiver
      int          mode;
      int          mode_left;
      int          hold_left;
      logic [7:0]  pattern;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      pattern   = 8'b1011_0010;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
            pattern   = 8'($urandom) | 8'h01;
         end
         mode_left--;
         pattern = {pattern[6:0], pattern[7]};
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (end_drain) begin
            rsp_tready = 1'b1;
         end else begin
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: rsp_tready = ($urandom_range(0, 3) == 0);
               default: rsp_tready = pattern[0];
            endcase
         end
      end
   end

   // Every curve point transfer is compared field by field with the oldest
   // expectation; a transfer with nothing expected is an error as well.
   always @(posedge clock) begin : check_curve
      curve_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (curve_expected.size() == 0) begin
            report_mismatch("unexpected curve point", 16'h0000, rsp_tdata[15:0]);
         end else begin
            want = curve_expected.pop_front();
            if (rsp_tdata[15:0] != want.x) begin
               report_mismatch("curve_x", want.x, rsp_tdata[15:0]);
            end
            if (rsp_tdata[31:16] != want.y) begin
               report_mismatch("curve_y", want.y, rsp_tdata[31:16]);
            end
            if (rsp_tlast != want.last) begin
               report_mismatch("last_of_segment", 16'(want.last), 16'(rsp_tlast));
            end
         end
      end
   end

   // Watchdog: counts cycles without any transfer on either stream.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int          random_sent;
      int          phase;
      int          phase_items;
      logic [6:0]  phase_cfg;
      clock              = 1'b0;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      rsp_tready         = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      held_count         = 0;
      held_x             = '{default: '0};
      held_y             = '{default: '0};
      segment_points_reg = CFG_RESET;
      error_count        = 0;
      burst_left         = 0;
      hold_request       = 1'b0;
      end_drain          = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, starting from the reset value of the register.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].set_cfg) write_segment_points(DIRECTED[r].cfg);
         send_point(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].typed,
                    DIRECTED[r].typed_x, DIRECTED[r].typed_y);
      end

      // Random part in phases, each opening with a register write. Phase
      // lengths are often not multiples of four, so groups often straddle a write.
      // After the edge values, most phases use short segments to keep the run
      // brief, and one in four draws any 7-bit value.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase < $size(EDGE_CFG)) begin
            phase_cfg = EDGE_CFG[phase];
         end else if ($urandom_range(0, 3) == 0) begin
            phase_cfg = 7'($urandom_range(0, 127));
         end else begin
            phase_cfg = 7'($urandom_range(2, 12));
         end
         write_segment_points(phase_cfg);
         phase_items = $urandom_range(6, 16);
         if (phase == HOLD_PHASE) begin
            // The receiver stalls while the sender keeps offering points.
            hold_request = 1'b1;
            phase_items  = 24;
         end
         for (int i = 0; i < phase_items; i++) begin
            send_point(pick_coord(), pick_coord(), 1'b0, 16'h0000, 16'h0000);
         end
         random_sent += phase_items;
         phase++;
      end

      // Leave a trailing group of three points open; it must never emit.
      while (held_count != 3) begin
         send_point(pick_coord(), pick_coord(), 1'b0, 16'h0000, 16'h0000);
      end

      req_tvalid = 1'b0;
      end_drain  = 1'b1;
      while (curve_expected.size() != 0) @(negedge clock);
      // Any stray curve point after the last expected one is caught here.
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/cbt_pkg.sv
hw/rtl/cubic_bezier_tessellator.sv
test/cubic_bezier_tessellator_tb.sv
